// ===== src/mnst_pkg.sv =====
// ----------------------------------------------------------------------------
// mnst_pkg: shared types, constants and tables for the MIDI sine tone core
// Operation codes passed from the front end to the tone engine, and the
// note phase-step and quarter-wave sine tables, built at elaboration.
// ----------------------------------------------------------------------------
package mnst_pkg;

  // Core sizing
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 12;
  localparam int TONE_SAMPLES    = 4096;
  localparam int REMAIN_W        = 13;
  localparam int SAMPLE_W        = 16;
  localparam int MAG_W           = SAMPLE_W - 1;
  localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
  localparam int QOFS_W          = SINE_TABLE_BITS - 2;
  localparam int QADDR_W         = SINE_TABLE_BITS - 1;
  localparam int NOTE_COUNT      = 128;

  // Operation queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // MIDI decode
  localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
  localparam logic       ACTION_TICK    = 1'b1;

  // Arithmetic constants
  localparam logic [63:0] SINE_PEAK   = 64'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] RATE_HZ     = 64'd44100;
  localparam logic [63:0] A4_HZ       = 64'd440;

  // 2^(k/12) in Q30
  localparam logic [63:0] SEMITONE_Q30 [0:11] = '{
    64'd1073741824, 64'd1137589835, 64'd1205234448, 64'd1276901417,
    64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
    64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
  };

  // Taylor series divisors (2k)(2k+1) for k = 1..7
  localparam logic [63:0] TAYLOR_DIV [0:6] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_STOP    = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [PHASE_BITS-1:0] step;
  } op_t;

  typedef logic [PHASE_BITS-1:0] step_tab_t [0:NOTE_COUNT-1];
  typedef logic [MAG_W-1:0]      qsine_tab_t [0:QUARTER];

  // Equal-tempered phase step per note, rounded half up
  function automatic step_tab_t build_step_tab();
    step_tab_t   tab;
    int          m;
    int          e;
    logic [63:0] num;
    logic [63:0] acc;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      m   = n + 3;
      e   = m / 12 + PHASE_BITS - 36;
      num = A4_HZ * SEMITONE_Q30[m % 12];
      if (e >= 0) begin
        acc = ((num << e) + RATE_HZ / 2) / RATE_HZ;
      end else begin
        acc = ((num + ((RATE_HZ / 2) << (-e))) / RATE_HZ) >> (-e);
      end
      tab[n] = acc[PHASE_BITS-1:0];
    end
    return tab;
  endfunction

  // Magnitude of 32767*sin(pi/2 * r/QUARTER), Q30 Taylor series, truncated
  function automatic logic [MAG_W-1:0] quarter_sine(input int r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    if (r == 0) begin
      return '0;
    end
    if (r >= QUARTER) begin
      return SINE_PEAK[MAG_W-1:0];
    end
    x    = (64'(r) * HALF_PI_Q30) / QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * SINE_PEAK) >> 30;
    if (v > SINE_PEAK) begin
      v = SINE_PEAK;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic qsine_tab_t build_qsine_tab();
    qsine_tab_t tab;
    for (int r = 0; r <= QUARTER; r++) begin
      tab[r] = quarter_sine(r);
    end
    return tab;
  endfunction

  localparam step_tab_t  STEP_TAB  = build_step_tab();
  localparam qsine_tab_t QSINE_TAB = build_qsine_tab();

endpackage

// ===== src/mnst_front.sv =====
// ----------------------------------------------------------------------------
// mnst_front: input decode
// Accepts input words, drops short messages, classifies the rest into
// tick / note-on / stop operations and looks up the note's phase step.
// ----------------------------------------------------------------------------
module mnst_front (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [7:0]                 in_status_byte,
  input  logic [6:0]                 in_note_number,
  input  logic [6:0]                 in_velocity,
  input  logic                       in_complete_message,
  input  logic                       fifo_full,
  output logic                       push,
  output mnst_pkg::op_t              push_op
);
  import mnst_pkg::*;

  logic accept;
  logic is_note_on;

  // Accept whenever the queue has room; short messages are simply dropped
  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  assign is_note_on = (in_status_byte[7:4] == STATUS_NOTE_ON) && (in_velocity != 7'd0);

  // Classify the word
  always_comb begin
    push_op.step = STEP_TAB[in_note_number];
    if (in_action == ACTION_TICK) begin
      push_op.kind = OP_TICK;
    end else if (is_note_on) begin
      push_op.kind = OP_NOTE_ON;
    end else begin
      push_op.kind = OP_STOP;
    end
  end

  assign push = accept && ((in_action == ACTION_TICK) || in_complete_message);

endmodule

// ===== src/mnst_fifo.sv =====
// ----------------------------------------------------------------------------
// mnst_fifo: operation queue
// Small register FIFO between the decoder and the tone engine.
// ----------------------------------------------------------------------------
module mnst_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mnst_pkg::op_t push_op,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output mnst_pkg::op_t head_op
);
  import mnst_pkg::*;

  op_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  assign full      = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== src/mnst_back.sv =====
// ----------------------------------------------------------------------------
// mnst_back: tone engine
// Holds phase, step and remaining-sample count, executes queued operations,
// reads the quarter-wave sine ROM and drives the registered output word.
// ----------------------------------------------------------------------------
module mnst_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  mnst_pkg::op_t        q_op,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_sample,
  output logic                 out_tone_active,
  output logic                 out_last_of_tone
);
  import mnst_pkg::*;

  // Tone state
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] step_r, step_nxt;
  logic [REMAIN_W-1:0]   rem_r, rem_nxt;

  // ROM stage
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_active_r;
  logic                  s1_last_r;
  logic                  s1_neg_r;
  logic [MAG_W-1:0]      mag_r;

  // Output stage
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                  out_active_r, out_active_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                       adv;
  logic                       playing;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [1:0]                 quad;
  logic [QOFS_W-1:0]          qofs;
  logic [QADDR_W-1:0]         rom_addr;
  logic [SAMPLE_W-1:0]        mag_ext;

  // Whole pipeline moves unless the output word is held
  assign adv     = !out_valid_r || !out_stall;
  assign q_pop   = adv && q_not_empty;
  assign playing = (rem_r != '0);

  // Table address from the top phase bits, mirrored in odd quadrants
  assign tab_idx  = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad     = tab_idx[SINE_TABLE_BITS-1 -: 2];
  assign qofs     = tab_idx[QOFS_W-1:0];
  assign rom_addr = quad[0] ? (QADDR_W'(QUARTER) - {1'b0, qofs}) : {1'b0, qofs};

  // Execute the head operation
  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    if (q_pop) begin
      case (q_op.kind)
        OP_TICK: begin
          if (playing) begin
            phase_nxt = phase_r + step_r;
            rem_nxt   = rem_r - 1'b1;
          end
        end
        OP_NOTE_ON: begin
          step_nxt  = q_op.step;
          phase_nxt = '0;
          rem_nxt   = REMAIN_W'(TONE_SAMPLES);
        end
        OP_STOP: begin
          rem_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // ROM stage valid: only ticks make an output word
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (adv) begin
      s1_valid_nxt = q_pop && (q_op.kind == OP_TICK);
    end
  end

  // Output word: sign the magnitude, zero when idle
  assign mag_ext = {1'b0, mag_r};
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_active_nxt = out_active_r;
    out_last_nxt   = out_last_r;
    if (adv) begin
      out_valid_nxt  = s1_valid_r;
      out_active_nxt = s1_active_r;
      out_last_nxt   = s1_active_r && s1_last_r;
      if (!s1_active_r) begin
        out_sample_nxt = '0;
      end else if (s1_neg_r) begin
        out_sample_nxt = -$signed(mag_ext);
      end else begin
        out_sample_nxt = $signed(mag_ext);
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      step_r      <= '0;
      rem_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      rem_r       <= rem_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ROM read and ROM-stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r       <= QSINE_TAB[rom_addr];
      s1_active_r <= playing;
      s1_last_r   <= (rem_r == REMAIN_W'(1));
      s1_neg_r    <= quad[1];
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_active_r <= out_active_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_tone_active  = out_active_r;
  assign out_last_of_tone = out_last_r;

endmodule

// ===== src/midi_note_sine_tone_generator_core.sv =====
// ----------------------------------------------------------------------------
// midi_note_sine_tone_generator_core: MIDI driven sine tone generator
// Note-on messages start a fixed-length DDS sine tone; every tick word
// returns one signed 16-bit sample.
//
//   Channel  Dir  Handshake          Word
//   in_      in   in_valid/in_stall  action, status, note, velocity, complete
//   out_     out  out_valid/out_stall sample, tone_active, last_of_tone
//
// One word is taken per clock while the operation queue has room; one tick
// sample leaves per clock while out_stall is low, with a single ROM read port.
// A tick's word passes the queue entry, then the ROM-stage register (queue pop
// with state update and ROM read), then the output register.
// Reset (rst_n low, synchronous) empties the queue and clears the tone; no
// clearing pass. out_stall holds the engine; in_stall rises only when the
// four-entry queue is full.
// ----------------------------------------------------------------------------
module midi_note_sine_tone_generator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [7:0]         in_status_byte,
  input  logic [6:0]         in_note_number,
  input  logic [6:0]         in_velocity,
  input  logic               in_complete_message,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_tone_active,
  output logic               out_last_of_tone
);
  import mnst_pkg::*;

  logic fifo_full;
  logic fifo_not_empty;
  logic push;
  logic pop;
  op_t  push_op;
  op_t  head_op;

  // Decode
  mnst_front u_front (
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_status_byte      (in_status_byte),
    .in_note_number      (in_note_number),
    .in_velocity         (in_velocity),
    .in_complete_message (in_complete_message),
    .fifo_full           (fifo_full),
    .push                (push),
    .push_op             (push_op)
  );

  // Operation queue
  mnst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (fifo_full),
    .not_empty (fifo_not_empty),
    .pop       (pop),
    .head_op   (head_op)
  );

  // Tone engine
  mnst_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (fifo_not_empty),
    .q_op             (head_op),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_tone_active  (out_tone_active),
    .out_last_of_tone (out_last_of_tone)
  );

endmodule
